### rtl/core/bftp_pkg.sv
// Shared constants, codes and interface types of the tape processor.
`timescale 1ns / 1ps
package bftp_pkg;

    localparam int DATA_DEPTH  = 1024;
    localparam int PROG_DEPTH  = 4096;
    localparam int INPUT_DEPTH = 64;

    localparam int DATA_AW  = $clog2(DATA_DEPTH);
    localparam int PROG_AW  = $clog2(PROG_DEPTH);
    localparam int INPUT_AW = $clog2(INPUT_DEPTH);

    // Widths of the counters that must hold the depth itself.
    localparam int PC_W    = PROG_AW + 1;
    localparam int QCNT_W  = INPUT_AW + 1;
    localparam int MSIZE_W = 11;
    localparam int DEPTH_W = PC_W + 1;

    // Item modes.
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_QUEUE = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;
    localparam logic [1:0] MODE_STEP  = 2'd3;

    // Run status codes.
    localparam logic [2:0] ST_RUN       = 3'd0;
    localparam logic [2:0] ST_END       = 3'd1;
    localparam logic [2:0] ST_EXIT      = 3'd2;
    localparam logic [2:0] ST_PTR_OVER  = 3'd3;
    localparam logic [2:0] ST_PTR_UNDER = 3'd4;
    localparam logic [2:0] ST_PC_OVER   = 3'd5;
    localparam logic [2:0] ST_PC_UNDER  = 3'd6;
    localparam logic [2:0] ST_FULL      = 3'd7;

    // Configuration register indexes.
    localparam logic [1:0] CFG_INIT  = 2'd0;
    localparam logic [1:0] CFG_CONST = 2'd1;
    localparam logic [1:0] CFG_MSIZE = 2'd2;

    // Instruction characters.
    localparam logic [7:0] OP_INC   = 8'h2B;
    localparam logic [7:0] OP_DEC   = 8'h2D;
    localparam logic [7:0] OP_RIGHT = 8'h3E;
    localparam logic [7:0] OP_LEFT  = 8'h3C;
    localparam logic [7:0] OP_OUT   = 8'h2E;
    localparam logic [7:0] OP_IN    = 8'h2C;
    localparam logic [7:0] OP_OPEN  = 8'h5B;
    localparam logic [7:0] OP_CLOSE = 8'h5D;
    localparam logic [7:0] OP_HALT  = 8'h40;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic fill;
        logic exec;
        logic scan_rd;
        logic scan_chk;
        logic emit;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic step_run;
        logic fill_last;
        logic scan_need;
        logic scan_done;
        logic slot_free;
    } dp_stat_t;

endpackage

### rtl/core/bftp_ctrl.sv
// Sequencing state machine of the tape processor.
`timescale 1ns / 1ps
module bftp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  bftp_pkg::dp_stat_t stat,
    output bftp_pkg::ctl_cmd_t cmd
);
    import bftp_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_FILL     = 6'b000010,
        S_EXEC     = 6'b000100,
        S_SCAN_RD  = 6'b001000,
        S_SCAN_CHK = 6'b010000,
        S_DONE     = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (mode == MODE_START)
                    begin
                        state_next = S_FILL;
                    end
                    else if (mode == MODE_STEP && stat.step_run)
                    begin
                        state_next = S_EXEC;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_FILL:
            begin
                cmd.fill = 1'b1;
                if (stat.fill_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = stat.scan_need ? S_SCAN_RD : S_DONE;
            end
            S_SCAN_RD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                cmd.scan_chk = 1'b1;
                state_next   = stat.scan_done ? S_DONE : S_SCAN_RD;
            end
            S_DONE:
            begin
                if (stat.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/bftp_datapath.sv
// Stores, pointers, instruction execution and result register of the tape processor.
`timescale 1ns / 1ps
module bftp_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [1:0]                    mode,
    input  logic [7:0]                    data_byte,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [bftp_pkg::MSIZE_W-1:0]  cfg_data,
    input  logic                          res_stall,
    output logic                          res_valid,
    output logic                          out_valid,
    output logic [7:0]                    out_byte,
    output logic [2:0]                    status,
    output logic [bftp_pkg::PC_W-1:0]     program_counter,
    output logic [bftp_pkg::DATA_AW-1:0]  data_pointer,
    input  bftp_pkg::ctl_cmd_t            cmd,
    output bftp_pkg::dp_stat_t            stat
);
    import bftp_pkg::*;

    // Memories.
    logic [7:0] prog_mem [PROG_DEPTH];
    logic [7:0] data_mem [DATA_DEPTH];
    logic [7:0] q_mem    [INPUT_DEPTH];
    logic [7:0] prog_q, data_q, q_q;

    // Control and architectural registers.
    logic [7:0]           init_reg, const_reg;
    logic [MSIZE_W-1:0]   msize_reg;
    logic [PC_W-1:0]      plen_reg, pc_reg, pc_next;
    logic [DATA_AW-1:0]   cp_reg, cp_next;
    logic [INPUT_AW-1:0]  head_reg, head_next;
    logic [QCNT_W-1:0]    qcnt_reg, qcnt_next;
    logic [2:0]           run_reg, run_next;
    logic                 full_reg, full_next;
    logic                 ov_reg, ov_next;
    logic [7:0]           ob_reg, ob_next;
    logic [PC_W-1:0]      scan_i_reg, scan_i_next;
    logic signed [DEPTH_W-1:0] depth_reg, depth_next;
    logic                 fwd_reg, fwd_next;
    logic [DATA_AW-1:0]   fill_cnt_reg;
    logic                 res_valid_reg;

    // Combinational helpers.
    logic [PROG_AW-1:0]   prog_raddr;
    logic                 prog_we, q_we, data_we;
    logic [DATA_AW-1:0]   data_waddr;
    logic [7:0]           data_wdata;
    logic [MSIZE_W-1:0]   cells;
    logic [MSIZE_W-1:0]   cp_plus;
    logic [PC_W-1:0]      adv_pc;
    logic signed [DEPTH_W-1:0] depth_step;
    logic                 scan_need, scan_done;

    // Cells in use, clamped to the memory depth.
    always_comb
    begin
        if (msize_reg == '0)
        begin
            cells = MSIZE_W'(1);
        end
        else if (msize_reg > MSIZE_W'(DATA_DEPTH))
        begin
            cells = MSIZE_W'(DATA_DEPTH);
        end
        else
        begin
            cells = msize_reg;
        end
    end

    assign cp_plus    = MSIZE_W'(cp_reg) + MSIZE_W'(1);
    assign prog_raddr = cmd.scan_rd ? scan_i_reg[PROG_AW-1:0] : pc_reg[PROG_AW-1:0];
    assign prog_we    = cmd.take && mode == MODE_LOAD && plen_reg < PC_W'(PROG_DEPTH);
    assign q_we       = cmd.take && mode == MODE_QUEUE && qcnt_reg < QCNT_W'(INPUT_DEPTH);

    // Bracket depth change for the character under the scan.
    always_comb
    begin
        if (prog_q == OP_OPEN)
        begin
            depth_step = depth_reg + DEPTH_W'(1);
        end
        else if (prog_q == OP_CLOSE)
        begin
            depth_step = depth_reg - DEPTH_W'(1);
        end
        else
        begin
            depth_step = depth_reg;
        end
    end

    // Item bookkeeping, instruction execution and bracket scan.
    always_comb
    begin
        pc_next     = pc_reg;
        cp_next     = cp_reg;
        head_next   = head_reg;
        qcnt_next   = qcnt_reg;
        run_next    = run_reg;
        full_next   = full_reg;
        ov_next     = ov_reg;
        ob_next     = ob_reg;
        scan_i_next = scan_i_reg;
        depth_next  = depth_reg;
        fwd_next    = fwd_reg;
        data_we     = 1'b0;
        data_waddr  = cp_reg;
        data_wdata  = data_q;
        scan_need   = 1'b0;
        scan_done   = 1'b0;
        adv_pc      = pc_reg + PC_W'(1);

        if (cmd.take)
        begin
            full_next = 1'b0;
            ov_next   = 1'b0;
            ob_next   = 8'd0;
            case (mode)
                MODE_LOAD:
                begin
                    full_next = !prog_we;
                end
                MODE_QUEUE:
                begin
                    full_next = !q_we;
                    if (q_we)
                    begin
                        qcnt_next = qcnt_reg + QCNT_W'(1);
                    end
                end
                MODE_START:
                begin
                    pc_next  = '0;
                    cp_next  = '0;
                    run_next = (plen_reg != '0) ? ST_RUN : ST_END;
                end
                default:
                begin
                    if (run_reg == ST_RUN && pc_reg >= plen_reg)
                    begin
                        run_next = ST_END;
                    end
                end
            endcase
        end

        if (cmd.fill)
        begin
            data_we    = 1'b1;
            data_waddr = fill_cnt_reg;
            data_wdata = init_reg;
        end

        if (cmd.exec)
        begin
            case (prog_q)
                OP_INC:
                begin
                    data_we    = 1'b1;
                    data_wdata = data_q + 8'd1;
                end
                OP_DEC:
                begin
                    data_we    = 1'b1;
                    data_wdata = data_q - 8'd1;
                end
                OP_RIGHT:
                begin
                    if (cp_plus >= cells)
                    begin
                        run_next = ST_PTR_OVER;
                    end
                    else
                    begin
                        cp_next = cp_reg + DATA_AW'(1);
                    end
                end
                OP_LEFT:
                begin
                    if (cp_reg == '0)
                    begin
                        run_next = ST_PTR_UNDER;
                    end
                    else
                    begin
                        cp_next = cp_reg - DATA_AW'(1);
                    end
                end
                OP_OUT:
                begin
                    ov_next = 1'b1;
                    ob_next = data_q;
                end
                OP_IN:
                begin
                    data_we = 1'b1;
                    if (qcnt_reg != '0)
                    begin
                        data_wdata = q_q;
                        head_next  = head_reg + INPUT_AW'(1);
                        qcnt_next  = qcnt_reg - QCNT_W'(1);
                    end
                    else
                    begin
                        data_wdata = const_reg;
                    end
                end
                OP_OPEN:
                begin
                    scan_need = (data_q == 8'd0);
                    fwd_next  = 1'b1;
                end
                OP_CLOSE:
                begin
                    scan_need = (data_q != 8'd0);
                    fwd_next  = 1'b0;
                end
                OP_HALT:
                begin
                    run_next = ST_EXIT;
                end
                default:
                begin
                end
            endcase
            scan_i_next = pc_reg;
            depth_next  = '0;
            // Instructions that complete here move on to the next one.
            if (!scan_need && run_next == ST_RUN)
            begin
                pc_next = adv_pc;
                if (adv_pc >= plen_reg)
                begin
                    run_next = ST_END;
                end
            end
        end

        if (cmd.scan_chk)
        begin
            depth_next = depth_step;
            adv_pc     = scan_i_reg + PC_W'(1);
            if (depth_step == '0)
            begin
                scan_done = 1'b1;
                pc_next   = adv_pc;
                if (adv_pc >= plen_reg)
                begin
                    run_next = ST_END;
                end
            end
            else if (fwd_reg)
            begin
                if (adv_pc >= plen_reg)
                begin
                    scan_done = 1'b1;
                    run_next  = ST_PC_OVER;
                end
                else
                begin
                    scan_i_next = adv_pc;
                end
            end
            else
            begin
                if (scan_i_reg == '0)
                begin
                    scan_done = 1'b1;
                    run_next  = ST_PC_UNDER;
                end
                else
                begin
                    scan_i_next = scan_i_reg - PC_W'(1);
                end
            end
        end
    end

    // Memory ports.
    always_ff @(posedge clk)
    begin
        if (prog_we)
        begin
            prog_mem[plen_reg[PROG_AW-1:0]] <= data_byte;
        end
        prog_q <= prog_mem[prog_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_mem[data_waddr] <= data_wdata;
        end
        data_q <= data_mem[cp_reg];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[INPUT_AW'(QCNT_W'(head_reg) + qcnt_reg)] <= data_byte;
        end
        q_q <= q_mem[head_reg];
    end

    // Register update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg      <= 8'd0;
            const_reg     <= 8'd0;
            msize_reg     <= MSIZE_W'(DATA_DEPTH);
            plen_reg      <= '0;
            pc_reg        <= '0;
            cp_reg        <= '0;
            head_reg      <= '0;
            qcnt_reg      <= '0;
            run_reg       <= ST_END;
            full_reg      <= 1'b0;
            ov_reg        <= 1'b0;
            ob_reg        <= 8'd0;
            scan_i_reg    <= '0;
            depth_reg     <= '0;
            fwd_reg       <= 1'b0;
            fill_cnt_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_INIT:  init_reg  <= cfg_data[7:0];
                    CFG_CONST: const_reg <= cfg_data[7:0];
                    CFG_MSIZE: msize_reg <= cfg_data;
                    default:   ;
                endcase
            end
            if (prog_we)
            begin
                plen_reg <= plen_reg + PC_W'(1);
            end
            pc_reg     <= pc_next;
            cp_reg     <= cp_next;
            head_reg   <= head_next;
            qcnt_reg   <= qcnt_next;
            run_reg    <= run_next;
            full_reg   <= full_next;
            ov_reg     <= ov_next;
            ob_reg     <= ob_next;
            scan_i_reg <= scan_i_next;
            depth_reg  <= depth_next;
            fwd_reg    <= fwd_next;
            if (cmd.take)
            begin
                fill_cnt_reg <= '0;
            end
            else if (cmd.fill)
            begin
                fill_cnt_reg <= fill_cnt_reg + DATA_AW'(1);
            end
            if (cmd.emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Result register; loaded when the transaction completes.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_valid       <= ov_reg;
            out_byte        <= ob_reg;
            status          <= full_reg ? ST_FULL : run_reg;
            program_counter <= pc_reg;
            data_pointer    <= cp_reg;
        end
    end

    assign res_valid      = res_valid_reg;
    assign stat.step_run  = (run_reg == ST_RUN) && (pc_reg < plen_reg);
    assign stat.fill_last = (fill_cnt_reg == DATA_AW'(DATA_DEPTH - 1));
    assign stat.scan_need = scan_need;
    assign stat.scan_done = scan_done;
    assign stat.slot_free = !res_valid_reg || !res_stall;

endmodule

### rtl/core/bf_tape_processor.sv
// Top level of the tape processor: controller and datapath.
//
// Usage: items enter on in_valid/in_stall with mode and data_byte; one
// result transaction per item leaves on res_valid/res_stall carrying
// out_valid, out_byte, status, program_counter and data_pointer.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Results are registered: load, queue and idle steps pass through the done
// state; an executed instruction passes through the execute state first,
// as the program and data memories have registered reads; a bracket jump
// adds a read and a check state per program byte scanned. Start sweeps all
// 1024 data cells, one per cycle. One item is in work at a time; the next
// can be accepted while the previous result still waits in the output
// register. Reset clears pointers, lengths and the queue and sets status
// to end; program and queue contents are undefined until written, data
// cells until the first start. When the receiver stalls, the result holds
// and the block stalls its input after at most one more item.
`timescale 1ns / 1ps
module bf_tape_processor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [7:0]  data_byte,
    output logic        res_valid,
    input  logic        res_stall,
    output logic        out_valid,
    output logic [7:0]  out_byte,
    output logic [2:0]  status,
    output logic [12:0] program_counter,
    output logic [9:0]  data_pointer,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);
    import bftp_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    // Sequencer.
    bftp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (mode),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Stores and execution.
    bftp_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .mode            (mode),
        .data_byte       (data_byte),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .res_stall       (res_stall),
        .res_valid       (res_valid),
        .out_valid       (out_valid),
        .out_byte        (out_byte),
        .status          (status),
        .program_counter (program_counter),
        .data_pointer    (data_pointer),
        .cmd             (cmd),
        .stat            (stat)
    );

endmodule

### bench/tb_bf_tape_processor.sv
// Self-checking testbench of the tape processor with its own instruction-level predictor.
`timescale 1ns / 1ps
module tb_bf_tape_processor;
    import bftp_pkg::*;

    typedef struct {
        logic        ov;
        logic [7:0]  ob;
        logic [2:0]  st;
        logic [12:0] pc;
        logic [9:0]  dp;
    } tape_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  mode = MODE_STEP;
    logic [7:0]  data_byte = 8'd0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic [2:0]  status;
    logic [12:0] program_counter;
    logic [9:0]  data_pointer;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_INIT;
    logic [10:0] cfg_data = 11'd0;

    // Predicted machine state and configuration.
    logic [7:0]  prog_mem [PROG_DEPTH];
    logic [7:0]  cells [DATA_DEPTH];
    logic [7:0]  in_fifo [INPUT_DEPTH];
    int          prog_len = 0;
    int          pc_idx = 0;
    int          cell_idx = 0;
    int          fifo_head = 0;
    int          fifo_cnt = 0;
    logic [2:0]  run_st = ST_END;
    logic [7:0]  init_val = 8'd0;
    logic [7:0]  const_val = 8'd0;
    logic [10:0] mem_size = 11'd1024;

    tape_res_t   expected_results [$];
    int          mismatches = 0;
    int          items_sent = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          hold_left = 0;

    bf_tape_processor dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .data_byte(data_byte),
        .res_valid(res_valid), .res_stall(res_stall),
        .out_valid(out_valid), .out_byte(out_byte), .status(status),
        .program_counter(program_counter), .data_pointer(data_pointer),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Clock and a single reset at the start of the run.
    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Runaway guard.
    initial
    begin
        #40_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    task automatic report(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Execute the instruction at the program counter.
    task automatic exec_instr(inout tape_res_t r);
        int pc;
        int i;
        int depth;
        int used;
        logic [7:0] c;
        pc = pc_idx;
        depth = 0;
        used = (mem_size == 0) ? 1 : ((mem_size > DATA_DEPTH) ? DATA_DEPTH : int'(mem_size));
        case (prog_mem[pc])
            OP_INC: cells[cell_idx] = cells[cell_idx] + 8'd1;
            OP_DEC: cells[cell_idx] = cells[cell_idx] - 8'd1;
            OP_RIGHT:
            begin
                if (cell_idx + 1 >= used)
                begin
                    run_st = ST_PTR_OVER;
                    return;
                end
                cell_idx++;
            end
            OP_LEFT:
            begin
                if (cell_idx == 0)
                begin
                    run_st = ST_PTR_UNDER;
                    return;
                end
                cell_idx--;
            end
            OP_OUT:
            begin
                r.ov = 1'b1;
                r.ob = cells[cell_idx];
            end
            OP_IN:
            begin
                if (fifo_cnt > 0)
                begin
                    cells[cell_idx] = in_fifo[fifo_head];
                    fifo_head = (fifo_head + 1) % INPUT_DEPTH;
                    fifo_cnt--;
                end
                else
                    cells[cell_idx] = const_val;
            end
            OP_OPEN:
            begin
                if (cells[cell_idx] == 8'd0)
                begin
                    i = pc;
                    forever
                    begin
                        c = prog_mem[i];
                        if (c == OP_OPEN) depth++;
                        else if (c == OP_CLOSE) depth--;
                        if (depth == 0) break;
                        i++;
                        if (i >= prog_len)
                        begin
                            run_st = ST_PC_OVER;
                            return;
                        end
                    end
                    pc = i;
                end
            end
            OP_CLOSE:
            begin
                if (cells[cell_idx] != 8'd0)
                begin
                    i = pc;
                    forever
                    begin
                        c = prog_mem[i];
                        if (c == OP_OPEN) depth++;
                        else if (c == OP_CLOSE) depth--;
                        if (depth == 0) break;
                        if (i == 0)
                        begin
                            run_st = ST_PC_UNDER;
                            return;
                        end
                        i--;
                    end
                    pc = i;
                end
            end
            OP_HALT:
            begin
                run_st = ST_EXIT;
                return;
            end
            default: ;
        endcase
        pc_idx = pc + 1;
        if (pc_idx >= prog_len) run_st = ST_END;
    endtask

    // Work out the result of one accepted transaction and queue it.
    task automatic predict_tape(input logic [1:0] m, input logic [7:0] b);
        tape_res_t r;
        r.ov = 1'b0;
        r.ob = 8'd0;
        case (m)
            MODE_LOAD:
            begin
                if (prog_len < PROG_DEPTH)
                begin
                    prog_mem[prog_len] = b;
                    prog_len++;
                    r.st = run_st;
                end
                else
                    r.st = ST_FULL;
            end
            MODE_QUEUE:
            begin
                if (fifo_cnt < INPUT_DEPTH)
                begin
                    in_fifo[(fifo_head + fifo_cnt) % INPUT_DEPTH] = b;
                    fifo_cnt++;
                    r.st = run_st;
                end
                else
                    r.st = ST_FULL;
            end
            MODE_START:
            begin
                pc_idx = 0;
                cell_idx = 0;
                foreach (cells[k]) cells[k] = init_val;
                run_st = (prog_len > 0) ? ST_RUN : ST_END;
                r.st = run_st;
            end
            default:
            begin
                if (run_st == ST_RUN)
                begin
                    if (pc_idx >= prog_len) run_st = ST_END;
                    else exec_instr(r);
                end
                r.st = run_st;
            end
        endcase
        r.pc = pc_idx[12:0];
        r.dp = cell_idx[9:0];
        expected_results.push_back(r);
    endtask

    // Offer one transaction, with random idle cycles before it.
    task automatic send_item(input logic [1:0] m, input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        data_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        predict_tape(m, b);
        items_sent++;
    endtask

    task automatic load_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(MODE_LOAD, s[i]);
    endtask

    // Wait until every expected result has arrived, with the sender idle.
    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [10:0] val);
        drain();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_INIT: init_val = val[7:0];
            CFG_CONST: const_val = val[7:0];
            default: mem_size = val;
        endcase
    endtask

    task automatic run_steps(input int n);
        repeat (n) send_item(MODE_STEP, 8'd0);
    endtask

    // Append a mostly balanced random program fragment.
    task automatic load_fragment(input int n);
        int open_cnt;
        int r;
        logic [7:0] c;
        open_cnt = 0;
        repeat (n)
        begin
            r = $urandom_range(99);
            if (r < 12) c = OP_INC;
            else if (r < 22) c = OP_DEC;
            else if (r < 34) c = OP_RIGHT;
            else if (r < 44) c = OP_LEFT;
            else if (r < 54) c = OP_OUT;
            else if (r < 62) c = OP_IN;
            else if (r < 72)
            begin
                c = OP_OPEN;
                open_cnt++;
            end
            else if (r < 82)
            begin
                c = (open_cnt > 0) ? OP_CLOSE : OP_INC;
                if (open_cnt > 0) open_cnt--;
            end
            else if (r < 84) c = OP_HALT;
            else if (r < 86) c = OP_CLOSE;
            else c = 8'($urandom_range(255));
            send_item(MODE_LOAD, c);
        end
        repeat (open_cnt) send_item(MODE_LOAD, OP_CLOSE);
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            res_stall <= 1'b1;
            hold_left--;
        end
        else
            res_stall <= ($urandom_range(99) < stall_pct);
    end

    // Compare each result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        tape_res_t e;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_results.size() == 0)
                report("unexpected result", 0, 0);
            else
            begin
                e = expected_results.pop_front();
                if (out_valid !== e.ov) report("out_valid", out_valid, e.ov);
                if (out_byte !== e.ob) report("out_byte", out_byte, e.ob);
                if (status !== e.st) report("status", status, e.st);
                if (program_counter !== e.pc) report("program_counter", program_counter, e.pc);
                if (data_pointer !== e.dp) report("data_pointer", data_pointer, e.dp);
            end
        end
    end

    // Steps and a start with no program loaded.
    task automatic test_empty_program;
        run_steps(2);
        send_item(MODE_START, 8'd0);
        run_steps(1);
    endtask

    // Directed head program whose faults are selected by the configuration.
    task automatic test_fault_paths;
        // Pointer moves right, left only when the cell is nonzero, then input and a
        // backward scan that runs past the start when the input byte is nonzero.
        load_text(">[<],].+.-[");
        // Memory size zero acts as one cell: first move right overflows.
        write_cfg(CFG_MSIZE, 11'd0);
        send_item(MODE_START, 8'd0);
        run_steps(2);
        // Oversized memory, nonzero fill: a left move to cell zero, then a backward jump.
        write_cfg(CFG_MSIZE, 11'd2047);
        write_cfg(CFG_INIT, 11'd255);
        send_item(MODE_START, 8'd0);
        run_steps(4);
        // Empty queue returns a nonzero constant: backward scan underflows.
        write_cfg(CFG_INIT, 11'd0);
        write_cfg(CFG_CONST, 11'd7);
        send_item(MODE_START, 8'd0);
        run_steps(5);
        // Queued zero byte: output, increment, decrement, then an unmatched forward scan.
        write_cfg(CFG_CONST, 11'd0);
        send_item(MODE_QUEUE, 8'd0);
        send_item(MODE_START, 8'd0);
        run_steps(4);
        send_item(MODE_LOAD, 8'hFF);
        run_steps(8);
        // Loading after the run has stopped, then a halt guarded by a zero cell.
        send_item(MODE_LOAD, OP_CLOSE);
        send_item(MODE_LOAD, 8'h00);
        load_text("x[@]");
        send_item(MODE_START, 8'd0);
        run_steps(18);
    endtask

    // Queue beyond its depth; bytes that do not fit are dropped.
    task automatic test_input_queue_full;
        send_idle_pct = 0;
        repeat (INPUT_DEPTH + 1) send_item(MODE_QUEUE, 8'($urandom_range(255)));
        drain();
    endtask

    // Long receiver hold-off while the sender keeps offering.
    task automatic test_backpressure;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_left = 300;
        run_steps(20);
        drain();
    endtask

    task automatic test_random_runs;
        int batch;
        int pick;
        batch = 0;
        while (items_sent < 1950)
        begin
            case (batch % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 66; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 66; end
                default: begin send_idle_pct = 23; stall_pct = 23; end
            endcase
            write_cfg(CFG_INIT, ($urandom_range(99) < 70) ? 11'd0 : 11'($urandom_range(2047)));
            write_cfg(CFG_CONST, ($urandom_range(99) < 70) ? 11'd0 : 11'($urandom_range(2047)));
            pick = $urandom_range(5);
            case (pick)
                0: write_cfg(CFG_MSIZE, 11'd1);
                1: write_cfg(CFG_MSIZE, 11'd1024);
                2: write_cfg(CFG_MSIZE, 11'($urandom_range(2047)));
                default: write_cfg(CFG_MSIZE, 11'($urandom_range(2, 1024)));
            endcase
            load_fragment($urandom_range(8, 30));
            if ($urandom_range(99) < 30)
                repeat ($urandom_range(1, 4)) send_item(MODE_QUEUE, 8'($urandom_range(255)));
            send_item(MODE_START, 8'd0);
            repeat ($urandom_range(20, 60))
            begin
                pick = $urandom_range(99);
                if (pick < 3) send_item(MODE_LOAD, 8'($urandom_range(255)));
                else if (pick < 5) send_item(MODE_QUEUE, 8'($urandom_range(255)));
                else send_item(MODE_STEP, 8'($urandom_range(255)));
            end
            batch++;
        end
        drain();
    endtask

    // Fill the program store to its depth; further loads are dropped.
    task automatic test_program_store_full;
        send_idle_pct = 0;
        stall_pct = 10;
        while (prog_len < PROG_DEPTH) send_item(MODE_LOAD, 8'($urandom_range(255)));
        send_item(MODE_LOAD, OP_INC);
        send_item(MODE_LOAD, 8'hFF);
        run_steps(2);
    endtask

    initial
    begin
        wait (rst_n === 1'b1);
        test_empty_program();
        test_fault_paths();
        test_backpressure();
        test_random_runs();
        test_input_queue_full();
        test_program_store_full();
        drain();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
